>>> hw/rtl/kway_timestamp_merge_defines.svh
// Assertion macros shared by the checker of the timestamp merge block.
// Depends on nothing; included by the checker file only.
`ifndef KWAY_TIMESTAMP_MERGE_DEFINES_SVH
`define KWAY_TIMESTAMP_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/kwtm_pkg.sv
// Package of the timestamp merge block: field widths, reset values and the
// types shared by the cells and the top level. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kwtm_pkg;

    localparam int SRC_W       = 4;
    localparam int STAMP_W     = 64;
    localparam int PAYLOAD_W   = 32;
    localparam int CNT_W       = 5;
    localparam int SOURCES_DEF = 16;
    // Only sixteen streams can be addressed by the source index.
    localparam int MAX_LIVE    = 16;
    localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic active;
        logic load;
        logic take;
    } t_cell_ctl;

    typedef struct packed {
        logic present;
        logic finished;
    } t_cell_stat;

    typedef struct packed {
        logic                 valid;
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
        logic [SRC_W-1:0]     idx;
    } t_cand;

endpackage

`default_nettype wire

>>> hw/rtl/kwtm_cell.sv
// One cell of the merge chain: holds the head event of one source and
// passes the running minimum on to its neighbour. Depends on kwtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwtm_cell
    import kwtm_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire                       i_stream_end,
    input  wire [STAMP_W-1:0]         i_stamp,
    input  wire [PAYLOAD_W-1:0]       i_payload,
    input  wire t_cand                i_cand,
    output t_cand                     o_cand,
    output t_cell_stat                o_stat
);

    localparam logic [SRC_W-1:0] MY_IDX = SRC_W'(CELL_IDX);

    logic                 r_present;
    logic                 r_finished;
    logic [STAMP_W-1:0]   r_stamp;
    logic [PAYLOAD_W-1:0] r_payload;
    t_cand                r_cand;
    t_cand                n_cand;
    logic                 load_ok;
    logic                 own_ok;

    // An item is taken only into an empty slot of a live source.
    assign load_ok = i_ctl.load && i_ctl.active && !r_finished && !r_present;
    assign own_ok  = i_ctl.active && r_present && !r_finished;

    always_comb begin
        n_cand = i_cand;
        // Strict compare keeps the lower source index on equal stamps.
        if (own_ok && (!i_cand.valid || (r_stamp < i_cand.stamp))) begin
            n_cand.valid   = 1'b1;
            n_cand.stamp   = r_stamp;
            n_cand.payload = r_payload;
            n_cand.idx     = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= 1'b0;
            r_finished <= 1'b0;
            r_cand     <= '0;
        end else begin
            if (load_ok) begin
                if (i_stream_end) begin
                    r_finished <= 1'b1;
                end else begin
                    r_present <= 1'b1;
                end
            end
            if (i_ctl.take) begin
                r_present <= 1'b0;
            end
            r_cand <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && !i_stream_end) begin
            r_stamp   <= i_stamp;
            r_payload <= i_payload;
        end
    end

    assign o_cand          = r_cand;
    assign o_stat.present  = r_present;
    assign o_stat.finished = r_finished;

endmodule

`default_nettype wire

>>> hw/rtl/kway_timestamp_merge.sv
// Top level of the timestamp merge block; instantiates the row of kwtm_cell
// cells and depends on kwtm_pkg.
//
// The block merges up to sixteen time-ordered event streams into a single
// stream ordered by 64-bit timestamp. Each input transfer brings either the
// next event of one source or an end-of-stream mark for it. Every source owns
// one cell in a chain; the cell keeps that source's head event, and in every
// cycle passes the smallest head seen so far to its right-hand neighbour, so
// the last cell presents the overall minimum once the chain has settled.
// Equal timestamps resolve to the lowest source index. Once every live source
// (below the active count and not ended) holds a head, the smallest head is
// emitted and that source's slot is freed; when every live source has ended,
// a single end result with merge_done set and zero fields is emitted, after
// which inputs are still taken but ignored until reset. An item for a source
// that already holds a head, has ended or is not active is dropped.
// Flow: each accepted item stalls the input until the block is done with it;
// an item that lets an event out also waits for the registered compare chain
// to settle through every cell, and for the output register to drain. The
// output register lets the next input transfer be taken while an emitted
// result still waits downstream.
// The active count is written through i_cfg_we / i_cfg_wdata; zero acts as
// one and values above sixteen or above SOURCES saturate.
`timescale 1ns / 1ps
`default_nettype none

module kway_timestamp_merge
    import kwtm_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CNT_W-1:0]       i_cfg_wdata,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire [SRC_W-1:0]       i_source_index,
    input  wire [STAMP_W-1:0]     i_stamp,
    input  wire [PAYLOAD_W-1:0]   i_payload_handle,
    input  wire                   i_stream_end,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [STAMP_W-1:0]    o_out_stamp,
    output logic [PAYLOAD_W-1:0]  o_out_payload,
    output logic [SRC_W-1:0]      o_out_source,
    output logic                  o_merge_done
);

    localparam int LIVE_MAX = (SOURCES < MAX_LIVE) ? SOURCES : MAX_LIVE;
    localparam logic [CNT_W-1:0] LIVE_MAX_C = CNT_W'(LIVE_MAX);
    localparam int WAIT_W = $clog2(SOURCES + 1);
    localparam logic [WAIT_W-1:0] WAIT_END = WAIT_W'(SOURCES);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_active_sources;
    logic [CNT_W-1:0]     eff_count;
    logic [WAIT_W-1:0]    r_wait;
    logic                 in_xfer;
    logic                 out_free;
    logic                 load_done;
    logic                 load_event;
    logic                 all_ended;
    logic                 head_missing;

    logic [SOURCES-1:0]   active_vec;
    logic [SOURCES-1:0]   present_vec;
    logic [SOURCES-1:0]   finished_vec;
    logic [SOURCES-1:0]   live_vec;
    t_cand                chain [SOURCES+1];
    t_cand                best;

    logic                 r_out_valid;
    logic [STAMP_W-1:0]   r_out_stamp;
    logic [PAYLOAD_W-1:0] r_out_payload;
    logic [SRC_W-1:0]     r_out_source;
    logic                 r_merge_done;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_sources <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active_sources <= i_cfg_wdata;
        end
    end

    always_comb begin
        eff_count = r_active_sources;
        if (eff_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (eff_count > LIVE_MAX_C) begin
            eff_count = LIVE_MAX_C;
        end
    end

    assign o_in_stall = (r_state == S_BUSY);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // The chain starts from an empty candidate at its left end.
    assign chain[0] = '0;
    assign best     = chain[SOURCES];

    for (genvar g = 0; g < SOURCES; g++) begin : g_cell
        t_cell_ctl  ctl;
        t_cell_stat stat;

        if (g < MAX_LIVE) begin : g_addr
            assign ctl.active = (CNT_W'(g) < eff_count);
            assign ctl.load   = in_xfer && (r_state == S_IDLE)
                                && (i_source_index == SRC_W'(g));
            assign ctl.take   = load_event && (best.idx == SRC_W'(g));
        end else begin : g_unused
            // Beyond what the source index can reach; never takes part.
            assign ctl.active = 1'b0;
            assign ctl.load   = 1'b0;
            assign ctl.take   = 1'b0;
        end

        kwtm_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_stream_end (i_stream_end),
            .i_stamp      (i_stamp),
            .i_payload    (i_payload_handle),
            .i_cand       (chain[g]),
            .o_cand       (chain[g+1]),
            .o_stat       (stat)
        );

        assign active_vec[g]   = ctl.active;
        assign present_vec[g]  = stat.present;
        assign finished_vec[g] = stat.finished;
    end

    assign live_vec     = active_vec & ~finished_vec;
    assign all_ended    = (live_vec == '0);
    assign head_missing = ((live_vec & ~present_vec) != '0);

    // The settle counter restarts on every accepted item, so once it reaches
    // its end the minimum at the end of the chain reflects the current heads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= '0;
        end else if (in_xfer) begin
            r_wait <= '0;
        end else if (r_wait != WAIT_END) begin
            r_wait <= r_wait + WAIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        load_done  = 1'b0;
        load_event = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (all_ended) begin
                    if (out_free) begin
                        load_done = 1'b1;
                        n_state   = S_DONE;
                    end
                end else if (head_missing) begin
                    n_state = S_IDLE;
                end else if ((r_wait == WAIT_END) && out_free) begin
                    load_event = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_done || load_event) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_done) begin
            r_out_stamp   <= '0;
            r_out_payload <= '0;
            r_out_source  <= '0;
            r_merge_done  <= 1'b1;
        end else if (load_event) begin
            r_out_stamp   <= best.stamp;
            r_out_payload <= best.payload;
            r_out_source  <= best.idx;
            r_merge_done  <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_stamp   = r_out_stamp;
    assign o_out_payload = r_out_payload;
    assign o_out_source  = r_out_source;
    assign o_merge_done  = r_merge_done;

endmodule

`default_nettype wire

>>> hw/rtl/kwtm_chk.sv
// Port-level checker for the timestamp merge block, bound to the top level.
// Depends on kwtm_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "kway_timestamp_merge_defines.svh"

module kwtm_chk
    import kwtm_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_stall,
    input  wire [SRC_W-1:0]      i_source_index,
    input  wire [STAMP_W-1:0]    i_stamp,
    input  wire [PAYLOAD_W-1:0]  i_payload_handle,
    input  wire                  i_stream_end,
    input  wire                  o_out_valid,
    input  wire                  i_out_stall,
    input  wire [STAMP_W-1:0]    o_out_stamp,
    input  wire [PAYLOAD_W-1:0]  o_out_payload,
    input  wire [SRC_W-1:0]      o_out_source,
    input  wire                  o_merge_done
);

    logic r_done_seen;

    // Remembers that the end result has been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_seen <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_merge_done) begin
            r_done_seen <= 1'b1;
        end
    end

    `KTM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_source_index) && $stable(i_stamp)
        && $stable(i_payload_handle) && $stable(i_stream_end),
        "stalled input transfer changed")
    `KTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_stamp) && $stable(o_out_payload)
        && $stable(o_out_source) && $stable(o_merge_done),
        "stalled result changed")
    `KTM_ASSERT_NOW(a_done_last, i_clk, i_rst_n, r_done_seen, !o_out_valid,
        "result after end of merge")
    `KTM_ASSERT_NOW(a_done_zero, i_clk, i_rst_n, o_out_valid && o_merge_done,
        (o_out_stamp == '0) && (o_out_payload == '0) && (o_out_source == '0),
        "end result carries data")

endmodule

bind kway_timestamp_merge kwtm_chk u_kwtm_chk (.*);

`default_nettype wire

>>> bench/kway_timestamp_merge_tb.sv
// Self-checking testbench of the timestamp merge block, kway_timestamp_merge.
// Depends on kwtm_pkg for the field widths and on the block's RTL; nothing else.
`timescale 1ns / 1ps

module kway_timestamp_merge_tb;

    import kwtm_pkg::*;

    // The bench runs the block at its default size of sixteen sources.
    localparam int NUM_SRC       = SOURCES_DEF;
    // An item that lets an event out keeps the chain busy while the minimum
    // settles through every cell, so SETTLE_CYCLES is a safe quiet spell before
    // a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 3 * (NUM_SRC + 2);
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 45;
    localparam int DIR_ROWS      = 14;

    // One emitted result as seen on the output side of the block.
    typedef struct packed {
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
        logic [SRC_W-1:0]     source;
        logic                 done;
    } t_merge_result;

    // How a directed row is checked: from the merge predictor, as typed in the
    // table, or as a row that must leave nothing behind.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_EVENT,
        ROW_SILENT
    } t_row_check;

    typedef struct {
        bit                   cfg_write;
        logic [CNT_W-1:0]     cfg_value;
        logic [SRC_W-1:0]     src;
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
        logic                 is_end;
        t_row_check           check;
        t_merge_result        want;
    } t_stim_row;

    // Clock, reset and every input of the block, known from time zero.
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_we         = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wdata      = '0;
    logic                 i_in_valid       = 1'b0;
    logic [SRC_W-1:0]     i_source_index   = '0;
    logic [STAMP_W-1:0]   i_stamp          = '0;
    logic [PAYLOAD_W-1:0] i_payload_handle = '0;
    logic                 i_stream_end     = 1'b0;
    logic                 i_out_stall      = 1'b0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [STAMP_W-1:0]   o_out_stamp;
    logic [PAYLOAD_W-1:0] o_out_payload;
    logic [SRC_W-1:0]     o_out_source;
    logic                 o_merge_done;

    // Private copy of the merge state, kept in step with every accepted
    // transfer on the input side.
    logic [CNT_W-1:0]     active_cnt;
    logic [STAMP_W-1:0]   head_stamp_r   [NUM_SRC];
    logic [PAYLOAD_W-1:0] head_payload_r [NUM_SRC];
    logic [NUM_SRC-1:0]   head_held;
    logic [NUM_SRC-1:0]   src_ended;
    bit                   end_sent;

    // Results the block still owes, oldest first.
    t_merge_result pending_events [$];

    int   error_count     = 0;
    int   items_accepted  = 0;
    int   items_loaded    = 0;
    int   results_checked = 0;
    int   cfg_writes      = 0;
    int   burst_left      = 0;
    int   cycle_count     = 0;
    int   stall_cycle     = 0;
    int   hold_left       = 0;
    int   holds_done      = 0;
    bit   hold_req        = 1'b0;

    t_stim_row        dir_rows  [DIR_ROWS];
    logic [CNT_W-1:0] phase_cfg [PHASES];

    kway_timestamp_merge #(
        .SOURCES          (NUM_SRC)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_source_index   (i_source_index),
        .i_stamp          (i_stamp),
        .i_payload_handle (i_payload_handle),
        .i_stream_end     (i_stream_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_stamp      (o_out_stamp),
        .o_out_payload    (o_out_payload),
        .o_out_source     (o_out_source),
        .o_merge_done     (o_merge_done)
    );

    // A 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Number of sources that take part: a count of zero acts as one, and
    // anything past sixteen (or past the build size) saturates.
    function automatic int unsigned sources_in_use(input logic [CNT_W-1:0] cnt);
        int unsigned n;
        n = (cnt == 0) ? 1 : int'(cnt);
        if (n > 16) n = 16;
        if (n > NUM_SRC) n = NUM_SRC;
        return n;
    endfunction

    // True when an item for this source would change the merge state, that is
    // the source takes part, has not ended and has a free head slot.
    function automatic bit slot_free(input logic [SRC_W-1:0] src);
        return !end_sent && (src < sources_in_use(active_cnt))
            && !src_ended[src] && !head_held[src];
    endfunction

    // Applies one accepted item to the private merge state and works out the
    // result it causes, if any.
    function automatic bit merge_step(input logic [SRC_W-1:0] src,
                                      input logic [STAMP_W-1:0] stamp,
                                      input logic [PAYLOAD_W-1:0] payload,
                                      input logic is_end,
                                      output t_merge_result res);
        int unsigned n;
        logic [NUM_SRC-1:0] mask;
        logic [NUM_SRC-1:0] live;
        int best;
        int i;
        bit found;
        res = '0;
        if (end_sent) return 1'b0;
        n = sources_in_use(active_cnt);
        mask = (n >= NUM_SRC) ? '1 : NUM_SRC'((64'd1 << n) - 1);
        if (slot_free(src)) begin
            if (is_end) begin
                src_ended[src] = 1'b1;
            end else begin
                head_stamp_r[src]   = stamp;
                head_payload_r[src] = payload;
                head_held[src]      = 1'b1;
            end
        end
        live = mask & ~src_ended;
        if (live == '0) begin
            end_sent = 1'b1;
            res.done = 1'b1;
            return 1'b1;
        end
        if ((live & ~head_held) != '0) return 1'b0;
        // Strictly smaller wins, so equal stamps stay with the lowest index.
        found = 1'b0;
        best  = 0;
        for (i = 0; i < n; i++) begin
            if (live[i] && (!found || head_stamp_r[i] < head_stamp_r[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        if (!found) return 1'b0;
        head_held[best] = 1'b0;
        res.stamp   = head_stamp_r[best];
        res.payload = head_payload_r[best];
        res.source  = SRC_W'(best);
        return 1'b1;
    endfunction

    // Offers one item and holds it steady until the block takes it. Values
    // are sampled at the edge, before the block's registers update.
    task automatic transfer_item(input logic [SRC_W-1:0] src,
                                 input logic [STAMP_W-1:0] stamp,
                                 input logic [PAYLOAD_W-1:0] payload,
                                 input logic is_end);
        i_in_valid       <= 1'b1;
        i_source_index   <= src;
        i_stamp          <= stamp;
        i_payload_handle <= payload;
        i_stream_end     <= is_end;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Sender pacing: bursts of random length, each followed by a random gap;
    // a quarter of the bursts run straight into the next with no gap at all.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // One item end to end: transfer, predict, queue what is owed, pace.
    task automatic run_item(input logic [SRC_W-1:0] src,
                            input logic [STAMP_W-1:0] stamp,
                            input logic [PAYLOAD_W-1:0] payload,
                            input logic is_end,
                            input t_row_check check,
                            input t_merge_result want,
                            output bit took);
        t_merge_result res;
        bit produced;
        transfer_item(src, stamp, payload, is_end);
        items_accepted++;
        took = slot_free(src);
        if (took) items_loaded++;
        produced = merge_step(src, stamp, payload, is_end, res);
        case (check)
            ROW_PREDICT: if (produced) pending_events.insert(pending_events.size(), res);
            ROW_EVENT:   pending_events.insert(pending_events.size(), want);
            default:     ;
        endcase
        pace_sender();
    endtask

    // The active count is only written once the block has gone quiet: every
    // owed result has come out and the compare chain has had time to settle.
    task automatic write_active_count(input logic [CNT_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        active_cnt   = value;
        cfg_writes++;
    endtask

    // Draws one item. Most go to a taking source that has a free head slot,
    // so the merge keeps moving; the rest are noise over the whole index range
    // and mostly get dropped. With guard set, source 0 never ends and at most
    // eight sources end, so the merge cannot finish before the last phase.
    task automatic make_item(input int end_pct, input bit guard,
                             output logic [SRC_W-1:0] src,
                             output logic [STAMP_W-1:0] stamp,
                             output logic [PAYLOAD_W-1:0] payload,
                             output logic is_end);
        int unsigned n;
        int free_src [$];
        int i;
        n = sources_in_use(active_cnt);
        for (i = 0; i < n; i++) begin
            if (slot_free(SRC_W'(i))) free_src.insert(free_src.size(), i);
        end
        if (free_src.size() == 0 || $urandom_range(0, 99) < 15) begin
            src    = SRC_W'($urandom_range(0, 15));
            is_end = ($urandom_range(0, 9) == 0);
        end else begin
            src    = SRC_W'(free_src[$urandom_range(0, free_src.size() - 1)]);
            is_end = ($urandom_range(0, 99) < end_pct);
        end
        if (guard && is_end && (src == 0 || $countones(src_ended) >= 8)) is_end = 1'b0;
        // Small stamps give plenty of ties; the others exercise every bit.
        case ($urandom_range(0, 3))
            0:       stamp = STAMP_W'($urandom_range(0, 3));
            1:       stamp = {32'hFFFF_FFFF, $urandom};
            default: stamp = {$urandom, $urandom};
        endcase
        payload = $urandom;
    endtask

    // Receiver: cycles through four stall patterns in turn (none,
    // light random, heavy random, periodic), and on request holds off for a
    // long stretch so that the block fills up and stalls its input.
    always @(posedge i_clk) begin
        stall_cycle++;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req     = 1'b0;
            hold_left    = HOLD_CYCLES;
            holds_done++;
            i_out_stall <= 1'b1;
        end else begin
            case ((stall_cycle >> 8) % 4)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ((stall_cycle % 7) < 3);
            endcase
        end
    end

    // Every result transfer is checked, field by field, against the oldest
    // owed result.
    always @(posedge i_clk) begin
        t_merge_result owed;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                error_count++;
                $error("unexpected result: stamp %h payload %h source %0d done %0b",
                       o_out_stamp, o_out_payload, o_out_source, o_merge_done);
            end else begin
                owed = pending_events.pop_front();
                results_checked++;
                if (o_out_stamp !== owed.stamp) begin
                    error_count++;
                    $error("out_stamp: expected %h, got %h", owed.stamp, o_out_stamp);
                end
                if (o_out_payload !== owed.payload) begin
                    error_count++;
                    $error("out_payload: expected %h, got %h", owed.payload, o_out_payload);
                end
                if (o_out_source !== owed.source) begin
                    error_count++;
                    $error("out_source: expected %0d, got %0d", owed.source, o_out_source);
                end
                if (o_merge_done !== owed.done) begin
                    error_count++;
                    $error("merge_done: expected %0b, got %0b", owed.done, o_merge_done);
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [SRC_W-1:0]     src;
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
        logic                 is_end;
        bit                   took;
        int                   phase;
        int                   loaded;
        int                   random_loaded;
        int                   k;

        // State after reset: sixteen sources, no heads, nothing ended.
        active_cnt = ACTIVE_RESET;
        head_held  = '0;
        src_ended  = '0;
        end_sent   = 1'b0;
        for (k = 0; k < NUM_SRC; k++) begin
            head_stamp_r[k]   = '0;
            head_payload_r[k] = '0;
        end

        // Directed table. Rows marked ROW_EVENT or ROW_SILENT carry the answer
        // as typed; ROW_PREDICT rows go to the predictor.
        dir_rows = '{
            // A count of zero acts as one: every item for source 0 comes
            // straight back out, at the extremes of stamp and payload.
            '{1'b1, 5'd0, 4'd0, 64'd0, 32'd0, 1'b0, ROW_EVENT,
              '{64'd0, 32'd0, 4'd0, 1'b0}},
            '{1'b0, 5'd0, 4'd0, '1, '1, 1'b0, ROW_EVENT,
              '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b0}},
            // Sources outside the active count are ignored, end marks too.
            '{1'b0, 5'd0, 4'd1, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0,
              ROW_SILENT, '0},
            '{1'b0, 5'd0, 4'd15, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b1,
              ROW_SILENT, '0},
            // Two sources: source 0 has no head yet, so nothing comes out.
            '{1'b1, 5'd2, 4'd1, 64'd5, 32'h11, 1'b0, ROW_SILENT, '0},
            // A second item while source 1 holds its head is dropped.
            '{1'b0, 5'd0, 4'd1, 64'd1, 32'h22, 1'b0, ROW_SILENT, '0},
            // Equal stamps: the lower source index goes first.
            '{1'b0, 5'd0, 4'd0, 64'd5, 32'h33, 1'b0, ROW_PREDICT, '0},
            '{1'b0, 5'd0, 4'd0, 64'd9, 32'h44, 1'b0, ROW_PREDICT, '0},
            // Source 1 ends, leaving source 0 as the only live stream.
            '{1'b0, 5'd0, 4'd1, 64'd0, 32'd0, 1'b1, ROW_PREDICT, '0},
            // Anything after the end of a source is ignored.
            '{1'b0, 5'd0, 4'd1, 64'd3, 32'h55, 1'b0, ROW_SILENT, '0},
            // Three sources; source 2 picks up a head while source 0 waits.
            '{1'b1, 5'd3, 4'd2, 64'd100, 32'h66, 1'b0, ROW_SILENT, '0},
            // Count drops to one with source 2 still holding a head: that head
            // is left out of the decision.
            '{1'b1, 5'd1, 4'd0, 64'd50, 32'h77, 1'b0, ROW_PREDICT, '0},
            // Back to three: the held head of source 2 counts again.
            '{1'b1, 5'd3, 4'd0, 64'd200, 32'h88, 1'b0, ROW_PREDICT, '0},
            '{1'b0, 5'd0, 4'd2, 64'd0, 32'd0, 1'b1, ROW_PREDICT, '0}
        };

        // Random phases, each under its own active count: saturating values,
        // the full sixteen, zero, and random ones.
        phase_cfg = '{5'd31, 5'd16, 5'd0, 5'd0, 5'd17, 5'd0, 5'd16};
        phase_cfg[2] = CNT_W'($urandom_range(2, 15));
        phase_cfg[5] = CNT_W'($urandom_range(0, 31));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].cfg_write) write_active_count(dir_rows[k].cfg_value);
            run_item(dir_rows[k].src, dir_rows[k].stamp, dir_rows[k].payload,
                     dir_rows[k].is_end, dir_rows[k].check, dir_rows[k].want, took);
        end

        // Only items that change the merge state count towards a phase, so
        // dropped noise does not shorten the run.
        random_loaded = 0;
        for (phase = 0; phase < PHASES; phase++) begin
            write_active_count(phase_cfg[phase]);
            loaded = 0;
            while (loaded < PHASE_ITEMS) begin
                make_item(4, 1'b1, src, stamp, payload, is_end);
                run_item(src, stamp, payload, is_end, ROW_PREDICT, '0, took);
                if (took) begin
                    loaded++;
                    random_loaded++;
                    // Part way through, the receiver holds off for a long
                    // stretch while the sender keeps offering items.
                    if (random_loaded == 150) hold_req = 1'b1;
                end
            end
        end

        // Last phase: all sixteen sources take part and end marks are common,
        // so every stream runs out and the single end result comes out.
        write_active_count(5'd31);
        while (!end_sent) begin
            make_item(50, 1'b0, src, stamp, payload, is_end);
            run_item(src, stamp, payload, is_end, ROW_PREDICT, '0, took);
        end

        // After the end result every transfer is taken and ignored.
        repeat (6) begin
            make_item(10, 1'b0, src, stamp, payload, is_end);
            run_item(src, stamp, payload, is_end, ROW_PREDICT, '0, took);
        end

        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input transfers (%0d changed the merge state), %0d results",
                 items_accepted, items_loaded, results_checked);
        $display("under %0d active-count writes, %0d long receiver hold-off(s), end result seen.",
                 cfg_writes, holds_done);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
